### src/iaf_pkg.sv
// ----------------------------------------------------------------------------
// iaf_pkg
// Shared types, codes and character helpers for the integer to ASCII
// formatter: input and result words, the classified job word and constants.
// ----------------------------------------------------------------------------
package iaf_pkg;

  // Width of the value that the wide mode uses, and the narrow mode width.
  localparam int VALUE_WIDTH = 64;
  localparam int NARROW_W    = 32;

  // Digit register: room for every decimal digit of the widest value.
  localparam int DEC_DIGITS = 20;
  localparam int DIG_W      = DEC_DIGITS * 4;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int HEX_BITS   = HEX_DIGITS * 4;
  localparam int COUNT_W    = $clog2(DEC_DIGITS + 1);
  localparam int STEP_W     = $clog2(VALUE_WIDTH + 1);

  // Depth of the job queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Conversion kinds.
  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEXL = 3'd2;
  localparam logic [2:0] OP_HEXU = 3'd3;
  localparam logic [2:0] OP_PTR  = 3'd4;

  // Characters.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // Input word.
  typedef struct packed {
    logic [2:0]  op;
    logic        wide;
    logic [63:0] value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } out_word_t;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] mag;
    logic                   dec;
    logic                   narrow;
    logic                   upper;
    logic                   neg;
    logic                   ptr;
  } job_t;

  // Status of the job queue as the back sees it.
  typedef struct packed {
    logic empty;
    job_t job;
  } queue_stat_t;

  // Map one digit value to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      return CH_ZERO + 8'(d);
    end else begin
      return base + 8'(d - 4'd10);
    end
  endfunction

endpackage

### src/iaf_front.sv
// ----------------------------------------------------------------------------
// iaf_front
// Classifies an incoming word: selects the active width, takes the
// magnitude of a negative signed value and decides base, case and prefix.
// ----------------------------------------------------------------------------
module iaf_front (
  input  iaf_pkg::in_word_t item,
  output iaf_pkg::job_t     job,
  output logic              job_ok
);
  import iaf_pkg::*;

  logic                   narrow;
  logic                   sign_bit;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag_raw;
  logic [VALUE_WIDTH-1:0] mag_neg;
  logic [NARROW_W-1:0]    low_neg;

  // Only the five defined kinds produce text.
  assign job_ok = (item.op == OP_SDEC) || (item.op == OP_UDEC) || (item.op == OP_HEXL) ||
                  (item.op == OP_HEXU) || (item.op == OP_PTR);

  // Select the active bits of the value.
  assign narrow   = !item.wide;
  assign mag_raw  = narrow ? VALUE_WIDTH'(item.value[NARROW_W-1:0])
                           : item.value[VALUE_WIDTH-1:0];
  assign sign_bit = narrow ? item.value[NARROW_W-1] : item.value[VALUE_WIDTH-1];
  assign neg      = (item.op == OP_SDEC) && sign_bit;

  // Two's complement magnitude; the most negative value maps onto itself,
  // which is exactly its unsigned magnitude.
  assign low_neg = NARROW_W'(~item.value[NARROW_W-1:0]) + NARROW_W'(1);
  assign mag_neg = narrow ? VALUE_WIDTH'(low_neg) : (~mag_raw + VALUE_WIDTH'(1));

  always_comb begin
    job.mag    = neg ? mag_neg : mag_raw;
    job.dec    = (item.op == OP_SDEC) || (item.op == OP_UDEC);
    job.narrow = narrow;
    job.upper  = (item.op == OP_HEXU);
    job.neg    = neg;
    job.ptr    = (item.op == OP_PTR);
  end

endmodule

### src/iaf_queue.sv
// ----------------------------------------------------------------------------
// iaf_queue
// Short job queue that decouples the classifying front from the
// converting back, so each side stalls on its own.
// ----------------------------------------------------------------------------
module iaf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  iaf_pkg::job_t         wr_job,
  output logic                  full,
  input  logic                  rd_en,
  output iaf_pkg::queue_stat_t  stat
);
  import iaf_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign stat.job   = slots[rd_ptr];
  assign do_wr      = wr_en && !full;
  assign do_rd      = rd_en && !stat.empty;

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("job queue count exceeds its depth");
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    (full && !do_rd) |=> (count == QCNT_W'(QDEPTH)))
    else $error("job queue count changed while full and not read");
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (stat.empty && wr_en) |=> (count == QCNT_W'(1)))
    else $error("write into empty queue not counted");
`endif

endmodule

### src/iaf_back.sv
// ----------------------------------------------------------------------------
// iaf_back
// Converts one job at a time: shift-and-add-3 binary to decimal for the
// decimal kinds, nibble alignment for hex, then emits the prefix and the
// digits into an output register, skipping leading zeros.
// ----------------------------------------------------------------------------
module iaf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  iaf_pkg::queue_stat_t qstat,
  output logic                 q_pop,
  output iaf_pkg::out_word_t   result,
  output logic                 empty,
  input  logic                 pop
);
  import iaf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                 state, state_next;
  logic [VALUE_WIDTH-1:0] sh, sh_next;
  logic [DIG_W-1:0]       digs, digs_next;
  logic [STEP_W-1:0]      step_cnt, step_cnt_next;
  logic [COUNT_W-1:0]     digit_count, digit_count_next;
  logic [1:0]             prefix_phase, prefix_phase_next;
  logic                   upper_case, upper_case_next;
  logic                   is_ptr, is_ptr_next;
  logic                   started, started_next;
  logic                   out_valid;
  logic                   out_free;
  logic                   emit;
  out_word_t              emit_word;
  logic [3:0]             top_digit;

  // One shift-and-add-3 step over all decimal digits.
  function automatic logic [DIG_W-1:0] dd_step(input logic [DIG_W-1:0] d, input logic bit_in);
    logic [DIG_W-1:0] adj;
    adj = d;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (d[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = d[i*4 +: 4] + 4'd3;
      end
    end
    return {adj[DIG_W-2:0], bit_in};
  endfunction

  assign out_free  = !out_valid || pop;
  assign top_digit = digs[DIG_W-1 -: 4];
  assign empty     = !out_valid;

  // Sequencer: load, convert, emit.
  always_comb begin
    state_next        = state;
    sh_next           = sh;
    digs_next         = digs;
    step_cnt_next     = step_cnt;
    digit_count_next  = digit_count;
    prefix_phase_next = prefix_phase;
    upper_case_next   = upper_case;
    is_ptr_next       = is_ptr;
    started_next      = started;
    q_pop             = 1'b0;
    emit              = 1'b0;
    emit_word         = '0;
    unique case (state)
      S_IDLE: begin
        if (!qstat.empty) begin
          q_pop             = 1'b1;
          upper_case_next   = qstat.job.upper;
          is_ptr_next       = qstat.job.ptr;
          started_next      = 1'b0;
          prefix_phase_next = qstat.job.ptr ? 2'd2 : (qstat.job.neg ? 2'd1 : 2'd0);
          if (qstat.job.dec) begin
            digs_next        = '0;
            digit_count_next = COUNT_W'(DEC_DIGITS);
            if (qstat.job.narrow) begin
              sh_next       = qstat.job.mag << (VALUE_WIDTH - NARROW_W);
              step_cnt_next = STEP_W'(NARROW_W);
            end else begin
              sh_next       = qstat.job.mag;
              step_cnt_next = STEP_W'(VALUE_WIDTH);
            end
            state_next = S_CONV;
          end else begin
            if (qstat.job.narrow) begin
              digs_next        = DIG_W'(qstat.job.mag[NARROW_W-1:0]) << (DIG_W - NARROW_W);
              digit_count_next = COUNT_W'(NARROW_W / 4);
            end else begin
              digs_next        = DIG_W'(HEX_BITS'(qstat.job.mag)) << (DIG_W - HEX_BITS);
              digit_count_next = COUNT_W'(HEX_DIGITS);
            end
            state_next = S_EMIT;
          end
        end
      end
      S_CONV: begin
        digs_next     = dd_step(digs, sh[VALUE_WIDTH-1]);
        sh_next       = sh << 1;
        step_cnt_next = step_cnt - STEP_W'(1);
        if (step_cnt == STEP_W'(1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (prefix_phase != 2'd0) begin
          // Sign or "0x" first.
          if (out_free) begin
            emit                = 1'b1;
            emit_word.last_char = 1'b0;
            if (is_ptr) begin
              emit_word.text_char = (prefix_phase == 2'd2) ? CH_ZERO : CH_X;
            end else begin
              emit_word.text_char = CH_MINUS;
            end
            prefix_phase_next = prefix_phase - 2'd1;
          end
        end else if (!started && (top_digit == 4'd0) && (digit_count > COUNT_W'(1))) begin
          // Leading zero: drop it without output.
          digs_next        = digs << 4;
          digit_count_next = digit_count - COUNT_W'(1);
        end else if (out_free) begin
          emit                = 1'b1;
          emit_word.text_char = digit_char(top_digit, upper_case);
          emit_word.last_char = (digit_count == COUNT_W'(1));
          digs_next           = digs << 4;
          digit_count_next    = digit_count - COUNT_W'(1);
          started_next        = 1'b1;
          if (digit_count == COUNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      digit_count  <= '0;
      prefix_phase <= '0;
      started      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      digit_count  <= digit_count_next;
      prefix_phase <= prefix_phase_next;
      started      <= started_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    sh         <= sh_next;
    digs       <= digs_next;
    step_cnt   <= step_cnt_next;
    upper_case <= upper_case_next;
    is_ptr     <= is_ptr_next;
    if (emit) begin
      result <= emit_word;
    end
  end

`ifndef SYNTHESIS
  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_word.last_char) |=> (state == S_IDLE))
    else $error("back did not return to idle after the last character");
  a_prefix_not_idle: assert property (@(posedge clk) disable iff (rst)
    (prefix_phase != 2'd0) |-> (state != S_IDLE))
    else $error("prefix pending while idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= COUNT_W'(DEC_DIGITS))
    else $error("digit count exceeds the digit register");
  a_conv_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |-> (step_cnt != '0))
    else $error("conversion running with no steps left");
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("character written over a waiting result");
`endif

endmodule

### src/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Top level: formats one integer per input word as ASCII text, one
// character per result word, with the final character marked.
// ----------------------------------------------------------------------------
// An input word is accepted whenever the two-entry job queue has room; the
// front classifies it in the same cycle and undefined kinds are dropped. The
// back takes one job at a time from the queue. A decimal job then shifts
// every value bit through the shift-and-add-3 converter (64 bits wide, 32
// narrow), then emits its prefix and walks the digit positions of the
// 20-digit register, dropping leading zeros without output. A hex or
// pointer job skips conversion and emits its prefix and one digit per
// nibble (16 wide, 8 narrow), also dropping leading zeros. Result words
// stall only when the output register is still held by the consumer.
module integer_to_ascii_formatter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  iaf_pkg::in_word_t  item,
  output logic               empty,
  input  logic               pop,
  output iaf_pkg::out_word_t result
);
  import iaf_pkg::*;

  job_t        front_job;
  logic        front_ok;
  queue_stat_t qstat;
  logic        q_pop;

  // Classify the incoming word.
  iaf_front u_front (
    .item   (item),
    .job    (front_job),
    .job_ok (front_ok)
  );

  // Hold classified jobs until the back is free.
  iaf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push && front_ok),
    .wr_job (front_job),
    .full   (full),
    .rd_en  (q_pop),
    .stat   (qstat)
  );

  // Convert and emit characters.
  iaf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .q_pop  (q_pop),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

endmodule
